// ===== hdl/fixed_slot_free_list_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fixed-slot free-list allocator
// Shorthands for clocked concurrent assertions, with and without the reset
// qualifier. They expect signals named clk and arst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Checked only while reset is released.
`define FSFL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included.
`define FSFL_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/fsfl_pkg.sv =====
// ----------------------------------------------------------------------------
// fsfl_pkg
// Shared types and constants of the fixed-slot free-list allocator.
// ----------------------------------------------------------------------------
package fsfl_pkg;

	localparam int POOL_W   = 11;
	localparam int SLOT_W   = 10;
	localparam int TDATA_W  = 16;
	localparam int S_USER_W = 2;
	localparam int M_USER_W = 3;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALLOC_RD,
		ST_CLEAR
	} state_t;

endpackage

// ===== hdl/fsfl_link_ram.sv =====
// ----------------------------------------------------------------------------
// fsfl_link_ram
// Link memory: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module fsfl_link_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/fixed_slot_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator
// LIFO free-list pool allocator with a head register and a link memory.
// ----------------------------------------------------------------------------
// One command is worked on at a time. A free, a rejected free, an allocate on
// an empty list and an unused command finish in the cycle they are taken; a
// granted allocate also passes ST_ALLOC_RD: the head link comes out of the
// link memory in the cycle after its address. A clear writes one link per
// cycle up to the last slot of the effective pool size. Each command yields
// one result beat; a new command is taken once the result register is free
// or being drained. Nothing is cleared after reset: the list starts empty.
module fixed_slot_free_list_allocator
	import fsfl_pkg::*;
#(
	parameter int SLOTS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [POOL_W-1:0]    cfg_data,   // pool_slots
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [TDATA_W-1:0]   s_tdata,    // slot_in[9:0], zero padding
	input  logic [S_USER_W-1:0]  s_tuser,    // command[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,    // slot_out[9:0], zero padding
	output logic [M_USER_W-1:0]  m_tuser     // granted[0], status[2:1]
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW = $clog2(SLOTS + 1);
	localparam int CW = (LW > POOL_W) ? LW : POOL_W;
	localparam logic [LW-1:0] NULL_C   = LW'(SLOTS);
	localparam logic [CW-1:0] SLOTS_CW = CW'(SLOTS);

	state_t          state_q, state_d;
	logic [POOL_W-1:0] pool_q;
	logic [LW-1:0]   head_q, head_d;
	logic [LW-1:0]   clr_q, clr_d;
	logic [LW-1:0]   eff_slots;
	logic            clr_last;
	logic            head_null;
	logic            accept;
	cmd_t            cmd;
	logic [SLOT_W-1:0] slot_in;
	logic            slot_bad;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [LW-1:0]   mem_wdata;
	logic [LW-1:0]   mem_rdata;

	logic            res_load;
	logic [SLOT_W-1:0] res_slot;
	logic            res_grant;
	status_t         res_status;

	logic            out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic            out_grant_q;
	status_t         out_status_q;

	assign cmd     = cmd_t'(s_tuser);
	assign slot_in = s_tdata[SLOT_W-1:0];

	// Pool size saturated to 1..SLOTS.
	always_comb begin
		if (pool_q == '0) begin
			eff_slots = LW'(1);
		end else if (CW'(pool_q) > SLOTS_CW) begin
			eff_slots = NULL_C;
		end else begin
			eff_slots = LW'(CW'(pool_q));
		end
	end

	assign slot_bad  = CW'(slot_in) >= CW'(eff_slots);
	assign clr_last  = clr_q == LW'(eff_slots - 1'b1);
	assign head_null = head_q == NULL_C;
	assign s_tready  = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept    = s_tvalid && s_tready;

	fsfl_link_ram #(
		.DEPTH (SLOTS),
		.AW    (AW),
		.DW    (LW)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (head_q[AW-1:0]),
		.rdata (mem_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_ALLOC && !head_null) begin
						state_d = ST_ALLOC_RD;
					end else if (cmd == CMD_CLEAR) begin
						state_d = ST_CLEAR;
					end
				end
			end
			ST_ALLOC_RD: begin
				state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		head_d     = head_q;
		clr_d      = clr_q;
		res_load   = 1'b0;
		res_slot   = '0;
		res_grant  = 1'b0;
		res_status = STAT_OK;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_ALLOC: begin
							// A non-empty list finishes once the head link is read.
							if (head_null) begin
								res_load   = 1'b1;
								res_status = STAT_EMPTY;
							end
						end
						CMD_FREE: begin
							res_load = 1'b1;
							if (slot_bad) begin
								res_status = STAT_RANGE;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(slot_in);
								mem_wdata = head_q;
								head_d    = LW'(slot_in);
							end
						end
						CMD_CLEAR: begin
							clr_d = '0;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			ST_ALLOC_RD: begin
				head_d    = mem_rdata;
				res_load  = 1'b1;
				res_slot  = SLOT_W'(head_q);
				res_grant = 1'b1;
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q[AW-1:0];
				if (clr_last) begin
					mem_wdata = NULL_C;
					head_d    = '0;
					res_load  = 1'b1;
				end else begin
					mem_wdata = LW'(clr_q + 1'b1);
					clr_d     = LW'(clr_q + 1'b1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pool_q      <= POOL_W'(1024);
			head_q      <= NULL_C;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			clr_q   <= clr_d;
			if (cfg_we) begin
				pool_q <= cfg_data;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_slot_q   <= res_slot;
			out_grant_q  <= res_grant;
			out_status_q <= res_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = TDATA_W'(out_slot_q);
	assign m_tuser  = {out_status_q, out_grant_q};

endmodule

// ===== hdl/fsfl_checker.sv =====
// ----------------------------------------------------------------------------
// fsfl_checker
// Port-level checks of the fixed-slot free-list allocator, bound to the top.
// ----------------------------------------------------------------------------
`include "fixed_slot_free_list_allocator_assert.svh"

module fsfl_checker
	import fsfl_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [TDATA_W-1:0]  m_tdata,
	input logic [M_USER_W-1:0] m_tuser
);

	// A granted slot always comes with a good status.
	`FSFL_ASSERT(a_grant_ok, m_tvalid && m_tuser[0] |-> m_tuser[2:1] == STAT_OK, "grant with bad status")

	// Without a grant the slot field reads zero.
	`FSFL_ASSERT(a_no_grant_zero, m_tvalid && !m_tuser[0] |-> m_tdata[SLOT_W-1:0] == '0, "slot without grant")

	// A waiting result blocks the input side.
	`FSFL_ASSERT(a_stall_blocks, m_tvalid && !m_tready |-> !s_tready, "input taken while result stalls")

	`FSFL_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	`FSFL_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "result beat during reset")

endmodule

bind fixed_slot_free_list_allocator fsfl_checker u_fsfl_checker (.*);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Free-list allocator testbench
// Drives allocate, free, clear and unused commands through the stream input,
// predicts every result beat with a behavioral copy of the free list, and
// checks the output stream field by field under random idling on both sides.
// Pool size settings include the extremes and sizes above and below range.
// ----------------------------------------------------------------------------
module tb;
	import fsfl_pkg::*;

	localparam int SLOTS = 1024;
	localparam logic [POOL_W-1:0] NULL_SLOT = POOL_W'(SLOTS);
	localparam int QUIET_LIMIT = 5000;
	localparam int ITEMS_PER_PHASE = 96;
	localparam int RANDOM_PHASES = 16;

	typedef struct packed {
		cmd_t              cmd;
		logic [SLOT_W-1:0] slot;
	} pool_cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              granted;
		logic [1:0]        status;
	} grant_t;

	logic                clk;
	logic                arst_n = 1'b1;
	logic                cfg_we = 1'b0;
	logic [POOL_W-1:0]   cfg_data = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata = '0;
	logic [S_USER_W-1:0] s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TDATA_W-1:0]  m_tdata;
	logic [M_USER_W-1:0] m_tuser;

	// Commands waiting for the driver, and results the block still owes.
	pool_cmd_t cmd_backlog[$];
	grant_t    pending_grants[$];

	// Behavioral copy of the allocator state.
	logic [POOL_W-1:0] free_head = NULL_SLOT;
	logic [POOL_W-1:0] next_free [SLOTS];
	logic [POOL_W-1:0] pool_reg = POOL_W'(1024);

	int sender_idle_pct = 20;
	int sink_stall_pct = 20;
	int mismatches = 0;
	int quiet_cycles = 0;
	int cmds_taken = 0;
	int results_seen = 0;
	int settings_used = 0;
	int n_granted = 0;
	int n_empty = 0;
	int n_range = 0;
	int n_clears = 0;

	fixed_slot_free_list_allocator #(.SLOTS(SLOTS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Pool size as the block uses it: zero acts as one, oversize as SLOTS.
	function automatic int unsigned live_pool(input logic [POOL_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > SLOTS)
			return SLOTS;
		return v;
	endfunction

	task automatic predict_grant(input pool_cmd_t c);
		grant_t      r;
		int unsigned n;
		r = '0;
		r.status = STAT_OK;
		n = live_pool(pool_reg);
		case (c.cmd)
			CMD_ALLOC: begin
				if (free_head < SLOTS) begin
					r.slot = free_head[SLOT_W-1:0];
					r.granted = 1'b1;
					free_head = next_free[free_head];
				end else begin
					r.status = STAT_EMPTY;
				end
			end
			CMD_FREE: begin
				if (c.slot >= n) begin
					r.status = STAT_RANGE;
				end else begin
					next_free[c.slot] = free_head;
					free_head = POOL_W'(c.slot);
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i + 1 < n; i++)
					next_free[i] = POOL_W'(i + 1);
				next_free[n - 1] = NULL_SLOT;
				free_head = '0;
				n_clears++;
			end
			default: ;
		endcase
		if (r.granted)
			n_granted++;
		else if (r.status == STAT_EMPTY)
			n_empty++;
		else if (r.status == STAT_RANGE)
			n_range++;
		pending_grants.push_back(r);
	endtask

	task automatic report_mismatch(input string field, input int got, input int want);
		mismatches++;
		$display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
	endtask

	// Sender: a new beat is offered only once the previous one has gone.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (cmd_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				pool_cmd_t c;
				c = cmd_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= TDATA_W'(c.slot);
				s_tuser <= c.cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Monitor: predicts on each accepted command beat, checks each result beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				pool_reg = cfg_data;
			if (s_tvalid && s_tready) begin
				cmds_taken++;
				predict_grant('{cmd: cmd_t'(s_tuser), slot: s_tdata[SLOT_W-1:0]});
			end
			if (m_tvalid && m_tready) begin
				if (pending_grants.size() == 0) begin
					report_mismatch("unexpected beat, slot_out", m_tdata[SLOT_W-1:0], 0);
				end else begin
					grant_t want;
					want = pending_grants.pop_front();
					if (m_tdata[SLOT_W-1:0] !== want.slot)
						report_mismatch("slot_out", m_tdata[SLOT_W-1:0], want.slot);
					if (m_tuser[0] !== want.granted)
						report_mismatch("granted", m_tuser[0], want.granted);
					if (m_tuser[2:1] !== want.status)
						report_mismatch("status", m_tuser[2:1], want.status);
				end
				results_seen++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d results outstanding",
					quiet_cycles, pending_grants.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic queue_cmd(input cmd_t cmd, input int unsigned slot);
		cmd_backlog.push_back('{cmd: cmd, slot: SLOT_W'(slot)});
	endtask

	// Returns at a falling edge once nothing is queued, offered or owed.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (cmd_backlog.size() > 0 || s_tvalid || pending_grants.size() > 0);
	endtask

	task automatic write_pool(input logic [POOL_W-1:0] v);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		settings_used++;
	endtask

	initial begin
		int unsigned n;
		int unsigned alloc_pct;
		int unsigned r;
		logic [POOL_W-1:0] size_sel;

		// A falling reset edge before the first clock edge clears the block at once.
		#1 arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty list after reset, top slot, double free, unused command.
		queue_cmd(CMD_ALLOC, 0);
		queue_cmd(CMD_FREE, 1023);
		queue_cmd(CMD_ALLOC, 0);
		queue_cmd(CMD_ALLOC, 0);
		queue_cmd(CMD_FREE, 0);
		queue_cmd(CMD_FREE, 0);
		queue_cmd(CMD_ALLOC, 0);
		queue_cmd(CMD_ALLOC, 0);
		queue_cmd(CMD_NOP, 1023);
		queue_cmd(CMD_CLEAR, 1023);
		queue_cmd(CMD_ALLOC, 0);
		queue_cmd(CMD_ALLOC, 0);

		// A size of zero behaves as a one-slot pool.
		write_pool('0);
		queue_cmd(CMD_CLEAR, 0);
		queue_cmd(CMD_ALLOC, 0);
		queue_cmd(CMD_ALLOC, 0);
		queue_cmd(CMD_FREE, 1);
		queue_cmd(CMD_FREE, 0);
		queue_cmd(CMD_ALLOC, 0);

		// Oversize saturates to the full pool.
		write_pool('1);
		queue_cmd(CMD_CLEAR, 0);
		queue_cmd(CMD_ALLOC, 0);
		queue_cmd(CMD_FREE, 1023);

		// Shrinking without a clear keeps the old chain but narrows frees.
		write_pool(POOL_W'(5));
		queue_cmd(CMD_FREE, 7);
		queue_cmd(CMD_ALLOC, 0);
		queue_cmd(CMD_ALLOC, 0);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(9))
				0:       size_sel = '0;
				1:       size_sel = '1;
				2:       size_sel = POOL_W'(SLOTS);
				3:       size_sel = POOL_W'($urandom_range(1, 2047));
				default: size_sel = POOL_W'($urandom_range(1, 40));
			endcase
			write_pool(size_sel);
			n = live_pool(size_sel);
			sender_idle_pct = (phase == 6) ? 0 : 20;
			sink_stall_pct = (phase == 6) ? 0 : 20;
			alloc_pct = $urandom_range(30, 70);
			if ($urandom_range(9) != 0)
				queue_cmd(CMD_CLEAR, $urandom_range(1023));
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				r = $urandom_range(99);
				if (r < 3)
					queue_cmd(CMD_CLEAR, $urandom_range(1023));
				else if (r < 6)
					queue_cmd(CMD_NOP, $urandom_range(1023));
				else if (r < 10)
					queue_cmd(CMD_FREE, $urandom_range(1023));
				else if (r < 10 + alloc_pct * 90 / 100)
					queue_cmd(CMD_ALLOC, $urandom_range(1023));
				else
					queue_cmd(CMD_FREE, $urandom_range(n - 1));
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Ran %0d commands over %0d pool sizes, %0d of them clears.",
			cmds_taken, settings_used, n_clears);
		$display("Saw %0d grants, %0d empty-pool answers and %0d rejected frees.",
			n_granted, n_empty, n_range);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
